FILE: hw/rtl/utf8cp_pkg.sv
// Package for the UTF-8 to Windows-1252 byte decoder.
// Holds the item types, decode phase codes, byte constants and mapping tables.
// No dependencies.
package utf8cp_pkg;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      byte_type in_byte;
      logic     in_last;
   } req_item_type;

   typedef struct packed {
      byte_type out_byte;
      logic     out_last;
   } rsp_item_type;

   typedef enum logic [10:0] {
      PH_IDLE = 11'b000_0000_0001,
      PH_C2   = 11'b000_0000_0010,
      PH_C3   = 11'b000_0000_0100,
      PH_C5   = 11'b000_0000_1000,
      PH_C6   = 11'b000_0001_0000,
      PH_CB   = 11'b000_0010_0000,
      PH_E2   = 11'b000_0100_0000,
      PH_E280 = 11'b000_1000_0000,
      PH_E282 = 11'b001_0000_0000,
      PH_E284 = 11'b010_0000_0000,
      PH_E2X  = 11'b100_0000_0000
   } phase_type;

   localparam byte_type LEAD_C2   = 8'hc2;
   localparam byte_type LEAD_C3   = 8'hc3;
   localparam byte_type LEAD_C5   = 8'hc5;
   localparam byte_type LEAD_C6   = 8'hc6;
   localparam byte_type LEAD_CB   = 8'hcb;
   localparam byte_type LEAD_E2   = 8'he2;
   localparam byte_type MID_80    = 8'h80;
   localparam byte_type MID_82    = 8'h82;
   localparam byte_type MID_84    = 8'h84;
   localparam byte_type C3_OR     = 8'h40;
   localparam byte_type SPACE     = 8'h20;
   localparam byte_type ZERO_BYTE = 8'h00;

   function automatic byte_type map_c5(input byte_type b);
      byte_type r;
      case (b)
         8'ha0:   r = 8'h8a;
         8'h92:   r = 8'h8c;
         8'h93:   r = 8'h9c;
         8'ha1:   r = 8'h9a;
         8'hb8:   r = 8'h9f;
         8'hbd:   r = 8'h8e;
         8'hbe:   r = 8'h9e;
         default: r = SPACE;
      endcase
      return r;
   endfunction

   function automatic byte_type map_c6(input byte_type b);
      byte_type r;
      case (b)
         8'h92:   r = 8'h83;
         default: r = SPACE;
      endcase
      return r;
   endfunction

   function automatic byte_type map_cb(input byte_type b);
      byte_type r;
      case (b)
         8'h86:   r = 8'h88;
         8'h9c:   r = 8'h98;
         default: r = SPACE;
      endcase
      return r;
   endfunction

   function automatic byte_type map_e280(input byte_type b);
      byte_type r;
      case (b)
         8'h93:   r = 8'h96;
         8'h94:   r = 8'h97;
         8'h98:   r = 8'h91;
         8'h99:   r = 8'h92;
         8'h9a:   r = 8'h82;
         8'h9c:   r = 8'h93;
         8'h9d:   r = 8'h94;
         8'h9e:   r = 8'h84;
         8'ha0:   r = 8'h86;
         8'ha1:   r = 8'h87;
         8'ha2:   r = 8'h95;
         8'ha6:   r = 8'h85;
         8'hb0:   r = 8'h89;
         8'hb9:   r = 8'h8b;
         8'hba:   r = 8'h9b;
         default: r = SPACE;
      endcase
      return r;
   endfunction

   function automatic byte_type map_e282(input byte_type b);
      byte_type r;
      case (b)
         8'hac:   r = 8'h80;
         default: r = SPACE;
      endcase
      return r;
   endfunction

   function automatic byte_type map_e284(input byte_type b);
      byte_type r;
      case (b)
         8'ha2:   r = 8'h99;
         default: r = SPACE;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/utf8cp_req_if.sv
// Input channel interface: valid/ready handshake carrying one UTF-8 byte item.
// Depends on utf8cp_pkg.
interface utf8cp_req_if;
   logic                valid;
   logic                ready;
   utf8cp_pkg::byte_type in_byte;
   logic                in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: hw/rtl/utf8cp_rsp_if.sv
// Result channel interface: valid/ready handshake carrying one Windows-1252 byte.
// Depends on utf8cp_pkg.
interface utf8cp_rsp_if;
   logic                valid;
   logic                ready;
   utf8cp_pkg::byte_type out_byte;
   logic                out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/utf8cp_in_stage.sv
// Input register stage: captures one request item per cycle while it is empty or its held item is taken.
// Depends on utf8cp_pkg and utf8cp_req_if.
module utf8cp_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   utf8cp_req_if.sink               req_stream,
   input  logic                     item_take,
   output logic                     item_valid,
   output utf8cp_pkg::req_item_type item
);

   logic                     valid_ff, valid_in;
   utf8cp_pkg::req_item_type item_ff, item_in;
   logic                     load;

   assign req_stream.ready = !valid_ff || item_take;
   assign load             = req_stream.valid && req_stream.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in        = 1'b1;
         item_in.in_byte = req_stream.in_byte;
         item_in.in_last = req_stream.in_last;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/utf8cp_decode.sv
// Decode logic: phase register plus lead/continuation byte mapping.
// Depends on utf8cp_pkg.
module utf8cp_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  utf8cp_pkg::req_item_type item,
   input  logic                     out_free,
   output logic                     item_take,
   output logic                     result_load,
   output utf8cp_pkg::rsp_item_type result
);

   utf8cp_pkg::phase_type phase_ff, phase_in, phase_next;
   utf8cp_pkg::byte_type  b, ob;
   logic                  emit;

   assign b         = item.in_byte;
   assign item_take = item_valid && out_free;

   always_comb begin
      emit       = 1'b1;
      ob         = b;
      phase_next = utf8cp_pkg::PH_IDLE;
      case (phase_ff)
         utf8cp_pkg::PH_C2:   ob = b;
         utf8cp_pkg::PH_C3:   ob = b | utf8cp_pkg::C3_OR;
         utf8cp_pkg::PH_C5:   ob = utf8cp_pkg::map_c5(b);
         utf8cp_pkg::PH_C6:   ob = utf8cp_pkg::map_c6(b);
         utf8cp_pkg::PH_CB:   ob = utf8cp_pkg::map_cb(b);
         utf8cp_pkg::PH_E280: ob = utf8cp_pkg::map_e280(b);
         utf8cp_pkg::PH_E282: ob = utf8cp_pkg::map_e282(b);
         utf8cp_pkg::PH_E284: ob = utf8cp_pkg::map_e284(b);
         utf8cp_pkg::PH_E2X:  ob = utf8cp_pkg::SPACE;
         utf8cp_pkg::PH_E2: begin
            emit = 1'b0;
            case (b)
               utf8cp_pkg::MID_80: phase_next = utf8cp_pkg::PH_E280;
               utf8cp_pkg::MID_82: phase_next = utf8cp_pkg::PH_E282;
               utf8cp_pkg::MID_84: phase_next = utf8cp_pkg::PH_E284;
               default:            phase_next = utf8cp_pkg::PH_E2X;
            endcase
         end
         default: begin
            emit = 1'b0;
            case (b)
               utf8cp_pkg::LEAD_C2: phase_next = utf8cp_pkg::PH_C2;
               utf8cp_pkg::LEAD_C3: phase_next = utf8cp_pkg::PH_C3;
               utf8cp_pkg::LEAD_C5: phase_next = utf8cp_pkg::PH_C5;
               utf8cp_pkg::LEAD_C6: phase_next = utf8cp_pkg::PH_C6;
               utf8cp_pkg::LEAD_CB: phase_next = utf8cp_pkg::PH_CB;
               utf8cp_pkg::LEAD_E2: phase_next = utf8cp_pkg::PH_E2;
               default:             emit       = 1'b1;
            endcase
         end
      endcase

      // truncated sequence at end of string: finish with one substitute byte (00 after C2, 40 after C3, else space)
      if (item.in_last && !emit) begin
         emit = 1'b1;
         case (phase_next)
            utf8cp_pkg::PH_C2: ob = utf8cp_pkg::ZERO_BYTE;
            utf8cp_pkg::PH_C3: ob = utf8cp_pkg::C3_OR;
            default:           ob = utf8cp_pkg::SPACE;
         endcase
      end
      if (item.in_last) begin
         phase_next = utf8cp_pkg::PH_IDLE;
      end
   end

   assign phase_in = item_take ? phase_next : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= utf8cp_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign result_load     = item_take && emit;
   assign result.out_byte = ob;
   assign result.out_last = item.in_last;

endmodule

FILE: hw/rtl/utf8cp_out_stage.sv
// Result register stage: holds one result item until the sink takes it.
// Depends on utf8cp_pkg and utf8cp_rsp_if.
module utf8cp_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     result_load,
   input  utf8cp_pkg::rsp_item_type result,
   output logic                     out_free,
   utf8cp_rsp_if.source             rsp_stream
);

   logic                     valid_ff, valid_in;
   utf8cp_pkg::rsp_item_type item_ff, item_in;

   assign out_free = !valid_ff || rsp_stream.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (result_load) begin
         valid_in = 1'b1;
         item_in  = result;
      end else if (rsp_stream.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_stream.valid    = valid_ff;
   assign rsp_stream.out_byte = item_ff.out_byte;
   assign rsp_stream.out_last = item_ff.out_last;

endmodule

FILE: hw/rtl/utf8_to_cp1252_byte_decoder.sv
// UTF-8 to Windows-1252 byte decoder, top level.
// Path: the accepted item is held in the input register, then its result is loaded into the result register.
// Throughput: 1 item per cycle while the result sink is ready; the one-hot phase register never holds the flow.
// Lead bytes and E2 second bytes give no result; an item with last set always gives exactly one.
// Synchronous active-high reset clears both stage valids and returns the phase to idle.
// Depends on utf8cp_pkg, utf8cp_req_if, utf8cp_rsp_if and the three stage modules.
module utf8_to_cp1252_byte_decoder (
   input  logic         clock,
   input  logic         reset,
   utf8cp_req_if.sink   req_stream,
   utf8cp_rsp_if.source rsp_stream
);

   logic                     item_valid, item_take;
   logic                     result_load, out_free;
   utf8cp_pkg::req_item_type item;
   utf8cp_pkg::rsp_item_type result;

   utf8cp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   utf8cp_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .item_take   (item_take),
      .result_load (result_load),
      .result      (result)
   );

   utf8cp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_free    (out_free),
      .rsp_stream  (rsp_stream)
   );

endmodule
